FILE: rtl/core/divider_timer_with_reload_assert.svh
// Assertion macros used by the timer checker.
`ifndef DIVIDER_TIMER_WITH_RELOAD_ASSERT_SVH
`define DIVIDER_TIMER_WITH_RELOAD_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define DTR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define DTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dtr_pkg.sv
package dtr_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_DIVIDER = 2'd0,
    REG_COUNTER = 2'd1,
    REG_MODULO  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_sel_t;

  localparam logic [7:0] CTRL_READ_ONES = 8'hf8;
  localparam logic [7:0] COUNT_MAX      = 8'hff;
  localparam int unsigned CTRL_EN_BIT   = 2;

  typedef struct packed {
    logic [7:0] write_data;
    reg_sel_t   reg_sel;
    req_t       req_type;
  } item_t;

  typedef struct packed {
    logic       timer_irq;
    logic [7:0] read_data;
  } result_t;

  // Enable gated divider tap picked by the rate select.
  function automatic logic sel_signal(logic en, logic [1:0] rate, logic [15:0] div);
    logic tap;
    unique case (rate)
      2'd0: tap = div[9];
      2'd1: tap = div[3];
      2'd2: tap = div[5];
      2'd3: tap = div[7];
      default: tap = 1'b0;
    endcase
    return en & tap;
  endfunction

endpackage

FILE: rtl/core/divider_timer_with_reload.sv
// Path: the input register takes the transaction, then the output register holds its result on out_tdata.
// Throughput: one transaction per cycle while out_tready holds; every tick, read, write or no-op gives one result.
// The state update for an item is computed combinationally in dtr_core and registered, so items flow back to back.
// Reset: rst_n synchronous, active low; divider loads DIV_START, all other timer state clears,
// both pipeline stages empty.
module divider_timer_with_reload
  import dtr_pkg::*;
#(
  parameter logic [15:0] DIV_START    = 16'd0,
  parameter int unsigned RELOAD_DELAY = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] write_data
  input  logic [3:0]  in_tuser,   // [1:0] req_type, [3:2] reg_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] timer_irq, [15:9] zero
);

  // Input register: holds one accepted transaction until the core consumes it.
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    advance;
  logic    slot_free;
  result_t core_result;
  result_t out_result;

  // The core step fires when the output register can take its result.
  assign advance   = s1_valid_r & slot_free;
  assign in_tready = ~s1_valid_r | slot_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.req_type   <= req_t'(in_tuser[1:0]);
      s1_item_r.reg_sel    <= reg_sel_t'(in_tuser[3:2]);
      s1_item_r.write_data <= in_tdata;
    end
  end

  // Timer state and the per-transaction update (tick, read, write).
  dtr_core #(
    .DIV_START    (DIV_START),
    .RELOAD_DELAY (RELOAD_DELAY)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .item       (s1_item_r),
    .result     (core_result)
  );

  // Output register: a waiting result that is taken frees the slot for the next result in the same cycle.
  dtr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (core_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result),
    .slot_free  (slot_free)
  );

  assign out_tdata = {7'd0, out_result.timer_irq, out_result.read_data};

endmodule

FILE: rtl/core/dtr_core.sv
module dtr_core
  import dtr_pkg::*;
#(
  parameter logic [15:0] DIV_START    = 16'd0,
  parameter int unsigned RELOAD_DELAY = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  output result_t result
);

  localparam logic [2:0] DELAY = 3'(RELOAD_DELAY);

  logic [15:0] div_r, div_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  mod_r, mod_nxt;
  logic        en_r, en_nxt;
  logic [1:0]  rate_r, rate_nxt;
  logic        wait_r, wait_nxt;
  logic [1:0]  dly_r, dly_nxt;
  logic        rtt_r, rtt_nxt;

  logic [15:0] div_inc;
  logic        sel_old;
  logic        bump;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= DIV_START;
      cnt_r  <= '0;
      mod_r  <= '0;
      en_r   <= 1'b0;
      rate_r <= '0;
      wait_r <= 1'b0;
      dly_r  <= '0;
      rtt_r  <= 1'b0;
    end else if (item_valid) begin
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
      mod_r  <= mod_nxt;
      en_r   <= en_nxt;
      rate_r <= rate_nxt;
      wait_r <= wait_nxt;
      dly_r  <= dly_nxt;
      rtt_r  <= rtt_nxt;
    end
  end

  always_comb begin
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    mod_nxt  = mod_r;
    en_nxt   = en_r;
    rate_nxt = rate_r;
    wait_nxt = wait_r;
    dly_nxt  = dly_r;
    rtt_nxt  = rtt_r;
    bump     = 1'b0;
    result   = '0;
    div_inc  = div_r + 16'd1;
    sel_old  = sel_signal(en_r, rate_r, div_r);

    unique case (item.req_type)
      REQ_TICK: begin
        rtt_nxt = 1'b0;
        div_nxt = div_inc;
        if (wait_r) begin
          // edges are not counted while the reload is pending
          if ({1'b0, dly_r} + 3'd1 >= DELAY) begin
            wait_nxt         = 1'b0;
            dly_nxt          = '0;
            cnt_nxt          = mod_r;
            rtt_nxt          = 1'b1;
            result.timer_irq = 1'b1;
          end else begin
            dly_nxt = dly_r + 2'd1;
          end
        end else begin
          bump = sel_old & ~sel_signal(en_r, rate_r, div_inc);
        end
      end
      REQ_READ: begin
        unique case (item.reg_sel)
          REG_DIVIDER: result.read_data = div_r[15:8];
          REG_COUNTER: result.read_data = cnt_r;
          REG_MODULO:  result.read_data = mod_r;
          REG_CONTROL: result.read_data = CTRL_READ_ONES | {5'd0, en_r, rate_r};
          default:     result.read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (item.reg_sel)
          REG_DIVIDER: begin
            // divider goes to zero, so the tap falls iff it was high
            div_nxt = '0;
            bump    = sel_old;
          end
          REG_COUNTER: begin
            if (!rtt_r) begin
              wait_nxt = 1'b0;
              dly_nxt  = '0;
              cnt_nxt  = item.write_data;
            end
          end
          REG_MODULO: begin
            mod_nxt = item.write_data;
            if (rtt_r) begin
              cnt_nxt = item.write_data;
            end
          end
          REG_CONTROL: begin
            en_nxt   = item.write_data[CTRL_EN_BIT];
            rate_nxt = item.write_data[1:0];
            bump     = sel_old & ~sel_signal(item.write_data[CTRL_EN_BIT],
                                             item.write_data[1:0], div_r);
          end
          default: ;
        endcase
      end
      REQ_NOP: ;
      default: ;
    endcase

    if (bump) begin
      if (cnt_r == COUNT_MAX) begin
        cnt_nxt  = '0;
        wait_nxt = 1'b1;
        dly_nxt  = '0;
      end else begin
        cnt_nxt = cnt_r + 8'd1;
      end
    end
  end

endmodule

FILE: rtl/core/dtr_out_stage.sv
module dtr_out_stage
  import dtr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result,
  output logic    slot_free
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign slot_free = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

FILE: rtl/core/dtr_checker.sv
`include "divider_timer_with_reload_assert.svh"

module dtr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic [3:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic in_fire;

  assign in_fire = in_tvalid & in_tready & (in_tdata == in_tdata) & (in_tuser == in_tuser);

  // stalled result holds
  `DTR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  // pipeline comes out of reset empty
  `DTR_ASSERT_IMPLY(a_reset_empty, !$past(rst_n), !out_tvalid, "result valid right after reset")
  // an empty output side never blocks input
  `DTR_ASSERT_IMPLY(a_ready_empty, !out_tvalid, in_tready, "input stalled with no result pending")
  // interrupt only comes from a tick, which reads zero; padding stays zero
  `DTR_ASSERT_IMPLY(a_irq_clean, out_tvalid, (out_tdata[15:9] == 7'd0) && (!out_tdata[8] || (out_tdata[7:0] == 8'd0)), "bad result encoding")
  // a transaction accepted with no result pending does not get stuck: the block is ready again or shows a result
  `DTR_ASSERT_NEXT(a_flow, in_fire && !out_tvalid, in_tready || out_tvalid, "accepted transaction stuck")

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/divider_timer_with_reload_test.sv
module divider_timer_with_reload_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dtr_pkg::*;

  localparam logic [15:0] DIV_START    = 16'd0;
  localparam int unsigned RELOAD_DELAY = 4;

  // Rate select codes and the divider bit each one taps.
  localparam logic [1:0] RATE_DIV1024 = 2'd0;
  localparam logic [1:0] RATE_DIV16   = 2'd1;
  localparam logic [1:0] RATE_DIV64   = 2'd2;
  localparam logic [1:0] RATE_DIV256  = 2'd3;
  localparam int TAP_BIT [4] = '{9, 3, 5, 7};

  localparam int RANDOM_ITEMS    = 1550;
  localparam int QUIET_TAIL      = 150;   // last items run with no idling at all
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_CYCLES = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] write_data
  logic [3:0]  in_tuser = '0;    // [1:0] req_type, [3:2] reg_sel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] read_data, [8] timer_irq, [15:9] zero

  divider_timer_with_reload #(
    .DIV_START   (DIV_START),
    .RELOAD_DELAY(RELOAD_DELAY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Timer model: own copy of the divider, counter, modulo, control and the
  // delayed reload bookkeeping. Advanced once per accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [15:0] div_m     = DIV_START;
  logic [7:0]  cnt_m     = '0;
  logic [7:0]  mod_m     = '0;
  logic        en_m      = 1'b0;
  logic [1:0]  rate_m    = RATE_DIV1024;
  logic        rl_wait_m = 1'b0;   // overflowed, reload pending
  logic [1:0]  rl_dly_m  = '0;     // ticks spent in the reload window
  logic        rl_tick_m = 1'b0;   // reload landed on the last tick

  // coverage tallies for the summary
  int overflows      = 0;
  int irqs_predicted = 0;
  int reload_cancels = 0;
  int hot_writes     = 0;          // counter/modulo writes on the reload tick
  int window_bumps   = 0;          // increments while the reload is pending

  result_t timer_out_q [$];
  int      errors = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  bit      src_idle = 1'b1;
  bit      sink_stalls = 1'b1;

  function automatic logic tap_level();
    return en_m & div_m[TAP_BIT[rate_m]];
  endfunction

  function automatic void count_up();
    if (rl_wait_m) window_bumps++;
    if (cnt_m == COUNT_MAX) begin
      // overflow: counter reads zero until the delayed reload
      cnt_m     = '0;
      rl_wait_m = 1'b1;
      rl_dly_m  = '0;
      overflows++;
    end else begin
      cnt_m = cnt_m + 8'd1;
    end
  endfunction

  function automatic result_t step_timer(req_t req, reg_sel_t sel, logic [7:0] data);
    result_t r;
    logic    was;
    r = '0;
    case (req)
      REQ_TICK: begin
        rl_tick_m = 1'b0;
        if (rl_wait_m) begin
          // edges are not counted inside the reload window
          div_m = div_m + 16'd1;
          if (int'(rl_dly_m) + 1 >= RELOAD_DELAY) begin
            rl_wait_m   = 1'b0;
            rl_dly_m    = '0;
            cnt_m       = mod_m;
            rl_tick_m   = 1'b1;
            r.timer_irq = 1'b1;
            irqs_predicted++;
          end else begin
            rl_dly_m = rl_dly_m + 2'd1;
          end
        end else begin
          was   = tap_level();
          div_m = div_m + 16'd1;
          if (was && !tap_level()) count_up();
        end
      end
      REQ_READ: begin
        case (sel)
          REG_DIVIDER: r.read_data = div_m[15:8];
          REG_COUNTER: r.read_data = cnt_m;
          REG_MODULO:  r.read_data = mod_m;
          default:     r.read_data = CTRL_READ_ONES | (8'(en_m) << CTRL_EN_BIT) | 8'(rate_m);
        endcase
      end
      REQ_WRITE: begin
        case (sel)
          REG_DIVIDER: begin
            was   = tap_level();
            div_m = '0;
            if (was && !tap_level()) count_up();
          end
          REG_COUNTER: begin
            if (rl_tick_m) begin
              hot_writes++;          // write lost to the reload
            end else begin
              if (rl_wait_m) reload_cancels++;
              rl_wait_m = 1'b0;
              rl_dly_m  = '0;
              cnt_m     = data;
            end
          end
          REG_MODULO: begin
            mod_m = data;
            if (rl_tick_m) begin
              cnt_m = data;          // reload tick: counter follows the modulo
              hot_writes++;
            end
          end
          default: begin
            was    = tap_level();
            en_m   = data[CTRL_EN_BIT];
            rate_m = data[1:0];
            if (was && !tap_level()) count_up();
          end
        endcase
      end
      default: ;                     // no-op: nothing moves
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side. One input transaction per call; may idle a random burst
  // first when idling is on. The model steps at the edge the transaction is taken.
  // A pinned result overrides the model's answer for directed rows.
  // ---------------------------------------------------------------------------
  task automatic issue_request(req_t req, reg_sel_t sel, logic [7:0] data,
                               bit pinned = 1'b0, logic [7:0] pinned_rd = '0);
    result_t want;
    int      gap;
    if (src_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {sel, req};
    do @(posedge clk); while (!in_tready);
    want = step_timer(req, sel, data);
    if (pinned) want = '{timer_irq: 1'b0, read_data: pinned_rd};
    timer_out_q.push_back(want);
    items_sent++;
  endtask

  // Sink side: random stall bursts while stalls are on.
  int sink_hold = 0;
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_stalls && rst_n && $urandom_range(0, 9) == 0) begin
      sink_hold  <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result check against the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (timer_out_q.size() == 0) begin
        $error("result with nothing outstanding: out_tdata=0x%04h", out_tdata);
        errors++;
      end else begin
        want = timer_out_q.pop_front();
        if (out_tdata[7:0] !== want.read_data) begin
          $error("read_data: expected 0x%02h, actual 0x%02h", want.read_data, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[8] !== want.timer_irq) begin
          $error("timer_irq: expected %0b, actual %0b", want.timer_irq, out_tdata[8]);
          errors++;
        end
        if (out_tdata[15:9] !== 7'd0) begin
          $error("pad: expected 0x00, actual 0x%02h", out_tdata[15:9]);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                 WATCHDOG_CYCLES, timer_out_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. reps repeats a row (runs of ticks). pinned rows carry a
  // result readable straight off the spec; the rest go through the model.
  // ---------------------------------------------------------------------------
  typedef struct {
    req_t       req;
    reg_sel_t   sel;
    logic [7:0] data;
    int         reps;
    bit         pinned;
    logic [7:0] rd;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(req_t req, reg_sel_t sel, logic [7:0] data, int reps,
                         bit pinned, logic [7:0] rd);
    dir_rows.push_back('{req: req, sel: sel, data: data, reps: reps, pinned: pinned, rd: rd});
  endtask

  initial begin : stimulus
    int         rand_items;
    int         burst_len;
    int         pick;
    reg_sel_t   sel;
    logic [7:0] data;

    // reset values straight after reset
    add_row(REQ_READ,  REG_DIVIDER, 8'h00, 1, 1'b1, 8'h00);
    add_row(REQ_READ,  REG_COUNTER, 8'hff, 1, 1'b1, 8'h00);
    add_row(REQ_READ,  REG_MODULO,  8'h00, 1, 1'b1, 8'h00);
    add_row(REQ_READ,  REG_CONTROL, 8'h00, 1, 1'b1, CTRL_READ_ONES);
    add_row(REQ_NOP,   REG_CONTROL, 8'hff, 1, 1'b1, 8'h00);
    add_row(REQ_WRITE, REG_MODULO,  8'hff, 1, 1'b1, 8'h00);
    add_row(REQ_WRITE, REG_CONTROL, 8'h05, 1, 1'b1, 8'h00);   // enable, divide by 16
    add_row(REQ_WRITE, REG_COUNTER, 8'hff, 1, 1'b1, 8'h00);
    add_row(REQ_READ,  REG_CONTROL, 8'h00, 1, 1'b1, 8'hfd);
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 8, 1'b0, 8'h00);   // divider bit 3 goes high
    // rate change drops the tapped bit: counts once, overflows
    add_row(REQ_WRITE, REG_CONTROL, 8'h04, 1, 1'b1, 8'h00);
    add_row(REQ_WRITE, REG_CONTROL, 8'h05, 1, 1'b1, 8'h00);
    // disabling drops the signal again: increment inside the reload window
    add_row(REQ_WRITE, REG_CONTROL, 8'h00, 1, 1'b1, 8'h00);
    add_row(REQ_READ,  REG_COUNTER, 8'h00, 1, 1'b0, 8'h00);
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 3, 1'b0, 8'h00);
    add_row(REQ_WRITE, REG_MODULO,  8'h80, 1, 1'b1, 8'h00);
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 1, 1'b0, 8'h00);   // reload lands, irq
    add_row(REQ_WRITE, REG_COUNTER, 8'h11, 1, 1'b1, 8'h00);   // lost on reload tick
    add_row(REQ_WRITE, REG_MODULO,  8'h42, 1, 1'b1, 8'h00);   // counter follows
    add_row(REQ_READ,  REG_COUNTER, 8'h00, 1, 1'b0, 8'h00);
    add_row(REQ_WRITE, REG_CONTROL, 8'h05, 1, 1'b1, 8'h00);
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 1, 1'b0, 8'h00);   // leaves the reload tick
    add_row(REQ_WRITE, REG_COUNTER, 8'hff, 1, 1'b1, 8'h00);
    add_row(REQ_WRITE, REG_DIVIDER, 8'h5a, 1, 1'b1, 8'h00);   // divider clear overflows
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 2, 1'b0, 8'h00);
    add_row(REQ_WRITE, REG_COUNTER, 8'h33, 1, 1'b1, 8'h00);   // cancels the reload
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 4, 1'b0, 8'h00);   // no irq now
    add_row(REQ_READ,  REG_COUNTER, 8'h00, 1, 1'b0, 8'h00);
    // slower rates: bit 5 falls once in the run of ticks
    add_row(REQ_WRITE, REG_CONTROL, {5'd0, 1'b1, RATE_DIV64}, 1, 1'b1, 8'h00);
    add_row(REQ_TICK,  REG_DIVIDER, 8'h00, 64, 1'b0, 8'h00);
    add_row(REQ_WRITE, REG_CONTROL, {5'd0, 1'b1, RATE_DIV256}, 1, 1'b1, 8'h00);
    add_row(REQ_READ,  REG_CONTROL, 8'h00, 1, 1'b1, 8'hff);
    add_row(REQ_READ,  REG_COUNTER, 8'h00, 1, 1'b0, 8'h00);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps)
        issue_request(dir_rows[i].req, dir_rows[i].sel, dir_rows[i].data,
                      dir_rows[i].pinned, dir_rows[i].rd);
    end

    // Random part. Mostly armed bursts: counting on, counter close to the
    // top, then a run of ticks with reads and writes sprinkled in, so the
    // reload window and reload tick get hit from every angle. The rest is
    // raw noise across all request types.
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        data = 8'($urandom);
        data[CTRL_EN_BIT] = ($urandom_range(0, 4) != 0);
        data[1:0] = ($urandom_range(0, 3) == 0) ? 2'($urandom) : RATE_DIV16;
        issue_request(REQ_WRITE, REG_CONTROL, data);
        data = $urandom_range(0, 1) ? 8'($urandom_range(248, 255)) : 8'($urandom);
        issue_request(REQ_WRITE, REG_COUNTER, data);
        rand_items += 2;
        if ($urandom_range(0, 1)) begin
          issue_request(REQ_WRITE, REG_MODULO, 8'($urandom));
          rand_items++;
        end
        burst_len = $urandom_range(20, 80);
        repeat (burst_len) begin
          pick = $urandom_range(0, 99);
          sel  = reg_sel_t'($urandom_range(0, 3));
          data = 8'($urandom);
          if (pick < 78) begin
            issue_request(REQ_TICK, sel, data);
          end else if (pick < 88) begin
            issue_request(REQ_READ, sel, data);
          end else begin
            if (sel == REG_CONTROL) data[CTRL_EN_BIT] = ($urandom_range(0, 5) != 0);
            else if (sel == REG_COUNTER && $urandom_range(0, 1))
              data = 8'($urandom_range(248, 255));
            issue_request(REQ_WRITE, sel, data);
          end
        end
        rand_items += burst_len;
      end else begin
        burst_len = $urandom_range(4, 16);
        repeat (burst_len)
          issue_request(req_t'($urandom_range(0, 3)), reg_sel_t'($urandom_range(0, 3)),
                        8'($urandom));
        rand_items += burst_len;
      end
      if (rand_items >= RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle    = 1'b0;
        sink_stalls = 1'b0;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (timer_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d overflows, %0d reload irqs",
             items_sent, results_seen, overflows, irqs_predicted);
    $display("reload window: %0d cancels, %0d reload-tick writes, %0d increments inside",
             reload_cancels, hot_writes, window_bumps);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
